@@ design/utsc_pkg.sv @@
// Shared types and constants for the sentence-case text filter.
// No dependencies; used by every module of the block.
package utsc_pkg;

	localparam int OUTQ_DEPTH_DEFAULT = 4;

	localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
	localparam logic [7:0] CHAR_QUEST   = 8'h3F;
	localparam logic [7:0] CHAR_EXCLAIM = 8'h21;
	localparam logic [7:0] CHAR_LOWER_I = 8'h69;
	localparam logic [7:0] CHAR_UPPER_I = 8'h49;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CASE_BIT     = 8'h20;

	// Pronoun tracking: nothing seen, one whitespace byte seen, or 'i' held.
	typedef enum logic [2:0] {
		PH_NONE  = 3'b001,
		PH_BLANK = 3'b010,
		PH_HELD  = 3'b100
	} phase_t;

	typedef struct packed {
		logic       last;
		logic [7:0] char;
	} entry_t;

	// Results produced by one accepted item, in text order.
	typedef struct packed {
		logic   push0;
		logic   push1;
		entry_t res0;
		entry_t res1;
	} push_t;

	typedef struct packed {
		phase_t phase;
		logic   after_end;
	} conv_status_t;

	function automatic logic is_letter(input logic [7:0] c);
		is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		is_blank = (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

endpackage

@@ design/utsc_conv.sv @@
// Case conversion and pronoun detection with their running state.
// Depends on utsc_pkg for types, character constants and classifiers.
module utsc_conv (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             char_in,
	input  logic                   last_in,
	output utsc_pkg::push_t        push,
	output utsc_pkg::conv_status_t status
);

	logic              after_end_q;
	utsc_pkg::phase_t  phase_q;
	logic [7:0]        held_q;

	logic [7:0]        cc;
	logic              after_end_d;
	logic              letter;
	logic              held_present;
	utsc_pkg::phase_t  phase_next;
	logic              hold_now;

	// A byte is held exactly while the phase says so.
	assign held_present = (phase_q == utsc_pkg::PH_HELD);
	assign letter       = utsc_pkg::is_letter(char_in);

	always_comb begin
		cc          = char_in;
		after_end_d = after_end_q;
		if ((char_in == utsc_pkg::CHAR_PERIOD) || (char_in == utsc_pkg::CHAR_QUEST) ||
		    (char_in == utsc_pkg::CHAR_EXCLAIM)) begin
			after_end_d = 1'b1;
		end else if (letter) begin
			cc          = after_end_q ? (char_in & ~utsc_pkg::CASE_BIT)
			                          : (char_in | utsc_pkg::CASE_BIT);
			after_end_d = 1'b0;
		end
	end

	always_comb begin
		case (phase_q)
			utsc_pkg::PH_HELD:  phase_next = utsc_pkg::is_blank(cc) ? utsc_pkg::PH_BLANK
			                                                        : utsc_pkg::PH_NONE;
			utsc_pkg::PH_BLANK: phase_next = (cc == utsc_pkg::CHAR_LOWER_I) ? utsc_pkg::PH_HELD
			                                                                : utsc_pkg::PH_NONE;
			default:            phase_next = utsc_pkg::is_blank(cc) ? utsc_pkg::PH_BLANK
			                                                        : utsc_pkg::PH_NONE;
		endcase
	end

	assign hold_now = (phase_next == utsc_pkg::PH_HELD) && !last_in;

	// When a held byte resolves it goes out first and the current byte second.
	always_comb begin
		push.push0     = accept && (held_present || !hold_now);
		push.push1     = accept && held_present;
		push.res0.last = last_in;
		push.res0.char = cc;
		push.res1.last = last_in;
		push.res1.char = cc;
		if (held_present) begin
			push.res0.last = 1'b0;
			push.res0.char = utsc_pkg::is_letter(cc) ? held_q : utsc_pkg::CHAR_UPPER_I;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_end_q <= 1'b1;
			phase_q     <= utsc_pkg::PH_NONE;
		end else if (accept) begin
			if (last_in) begin
				after_end_q <= 1'b1;
				phase_q     <= utsc_pkg::PH_NONE;
			end else begin
				after_end_q <= after_end_d;
				phase_q     <= phase_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_now) begin
			held_q <= cc;
		end
	end

	assign status.phase     = phase_q;
	assign status.after_end = after_end_q;

endmodule

@@ design/utsc_outq.sv @@
// Result queue: takes up to two items per cycle, hands out one per cycle while out_ready is high.
// Depends on utsc_pkg for the entry and push types.
module utsc_outq #(
	parameter int DEPTH = utsc_pkg::OUTQ_DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  utsc_pkg::push_t           push,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                char_out,
	output logic                      last_out,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	utsc_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic [PW-1:0]    wr_ptr_p1;
	logic             pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_p1 = ptr_inc(wr_ptr_q);
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= push.res0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_p1] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push1) begin
				wr_ptr_q <= ptr_inc(wr_ptr_p1);
			end else if (push.push0) begin
				wr_ptr_q <= wr_ptr_p1;
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.push0) + CW'(push.push1) - CW'(pop);
		end
	end

	assign char_out = mem_q[rd_ptr_q].char;
	assign last_out = mem_q[rd_ptr_q].last;
	assign count    = count_q;

endmodule

@@ design/upper_text_to_sentence_case_top.sv @@
// Sentence-case filter: one byte in per cycle while in_ready is high; results are
// registered in the result queue. A candidate pronoun 'i' is held until the next item arrives.
// Throughput is one item per cycle while the queue has room; the result queue drains one byte
// per cycle while out_ready is high, and the block takes new items while it has room for two results.
// Reset (arst_n, asynchronous): queue empty, sentence start pending, no byte held.
// State also returns to reset values after each item marked last.
module upper_text_to_sentence_case_top #(
	parameter int OUTQ_DEPTH = utsc_pkg::OUTQ_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       last_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_out,
	output logic       last_out
);

	localparam int CW = $clog2(OUTQ_DEPTH + 1);

	utsc_pkg::push_t        push;
	utsc_pkg::conv_status_t status;
	logic [CW-1:0]          count;
	logic                   accept;

	// Room for two results is needed, since one item may release two bytes.
	assign in_ready = (count <= CW'(OUTQ_DEPTH - 2));
	assign accept   = in_valid && in_ready;

	utsc_conv u_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.char_in (char_in),
		.last_in (last_in),
		.push    (push),
		.status  (status)
	);

	utsc_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.last_out  (last_out),
		.count     (count)
	);

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(OUTQ_DEPTH))
		else $error("result queue count exceeds its depth");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_in) |=> (status.phase == utsc_pkg::PH_NONE) && status.after_end)
		else $error("state not cleared after last item");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> (push.push0 && accept))
		else $error("second result pushed without first");

	a_last_not_held: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_in) |-> push.push0)
		else $error("last item produced no result");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the sentence-case text filter.
// Needs utsc_pkg and upper_text_to_sentence_case_top; predicts every output byte in a
// scoreboard class and drives both valid/ready channels with random gaps and stalls.

// Tracks the expected output stream: it converts each accepted item and queues the
// bytes that the item releases.
class sentence_case_board;
	utsc_pkg::entry_t expected_bytes[$];
	bit after_end;
	utsc_pkg::phase_t phase;
	logic [7:0] held_char;
	bit held_flag;
	int errors;
	int results_checked;

	function new();
		errors = 0;
		results_checked = 0;
		clear_state();
	endfunction

	function void clear_state();
		after_end = 1'b1;
		phase = utsc_pkg::PH_NONE;
		held_char = 8'h00;
		held_flag = 1'b0;
	endfunction

	function bit is_alpha(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function bit is_space(logic [7:0] c);
		return c == utsc_pkg::CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function void push_byte(logic [7:0] c, bit last);
		utsc_pkg::entry_t e;
		e.char = c;
		e.last = last;
		expected_bytes.push_back(e);
	endfunction

	function void note_item(logic [7:0] c, bit last);
		logic [7:0] v;
		utsc_pkg::phase_t nxt;
		v = c;
		if (v == utsc_pkg::CHAR_PERIOD || v == utsc_pkg::CHAR_QUEST ||
				v == utsc_pkg::CHAR_EXCLAIM) begin
			after_end = 1'b1;
		end else if (is_alpha(v)) begin
			v = after_end ? (v & ~utsc_pkg::CASE_BIT) : (v | utsc_pkg::CASE_BIT);
			after_end = 1'b0;
		end
		// A held 'i' is resolved by the converted byte that follows it.
		if (held_flag) begin
			push_byte(is_alpha(v) ? held_char : utsc_pkg::CHAR_UPPER_I, 1'b0);
			held_flag = 1'b0;
			nxt = is_space(v) ? utsc_pkg::PH_BLANK : utsc_pkg::PH_NONE;
		end else if (phase == utsc_pkg::PH_BLANK) begin
			nxt = (v == utsc_pkg::CHAR_LOWER_I) ? utsc_pkg::PH_HELD : utsc_pkg::PH_NONE;
		end else begin
			nxt = is_space(v) ? utsc_pkg::PH_BLANK : utsc_pkg::PH_NONE;
		end
		phase = nxt;
		if (nxt == utsc_pkg::PH_HELD && !last) begin
			held_char = v;
			held_flag = 1'b1;
			return;
		end
		push_byte(v, last);
		if (last)
			clear_state();
	endfunction

	task report_mismatch(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task check_item(logic [7:0] c, logic last);
		utsc_pkg::entry_t e;
		results_checked++;
		if (expected_bytes.size() == 0) begin
			report_mismatch($sformatf("unexpected byte %02h last %0b", c, last));
			return;
		end
		e = expected_bytes.pop_front();
		if (c !== e.char)
			report_mismatch($sformatf("char_out %02h, expected %02h", c, e.char));
		if (last !== e.last)
			report_mismatch($sformatf("last_out %0b, expected %0b (byte %02h)",
				last, e.last, e.char));
	endtask

	task flush_leftovers();
		utsc_pkg::entry_t e;
		while (expected_bytes.size() > 0) begin
			e = expected_bytes.pop_front();
			report_mismatch($sformatf("byte %02h last %0b never came out", e.char, e.last));
		end
	endtask
endclass

module testbench;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] char_in;
	logic last_in;
	logic out_valid;
	logic out_ready;
	logic [7:0] char_out;
	logic last_out;

	sentence_case_board board;
	int items_sent;

	upper_text_to_sentence_case_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_in(char_in),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_out(char_out),
		.last_out(last_out)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mostly upper-case text with plenty of spaces, lone I's and sentence ends; also lower-case and random bytes.
	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 8'($urandom_range(8'h41, 8'h5A));
		if (r < 54)
			return utsc_pkg::CHAR_UPPER_I;
		if (r < 70)
			return utsc_pkg::CHAR_SPACE;
		if (r < 75)
			return 8'($urandom_range(8'h09, 8'h0D));
		if (r < 83) begin
			case ($urandom_range(0, 2))
				0: return utsc_pkg::CHAR_PERIOD;
				1: return utsc_pkg::CHAR_QUEST;
				default: return utsc_pkg::CHAR_EXCLAIM;
			endcase
		end
		if (r < 89)
			return 8'($urandom_range(8'h61, 8'h7A));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_item(input logic [7:0] c, input bit last, input bit burst);
		int gap;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		last_in <= last;
		do @(posedge clk); while (!in_ready);
		board.note_item(c, last);
		items_sent++;
	endtask

	task automatic send_text(input string s, input bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], last_at_end && (i == s.len() - 1), 1'b0);
	endtask

	task automatic send_random_message();
		int len;
		bit burst;
		bit noise;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
		burst = ($urandom_range(0, 3) == 0);
		noise = ($urandom_range(0, 7) == 0);
		for (int i = 0; i < len; i++)
			send_item(noise ? 8'($urandom_range(0, 255)) : pick_text_byte(),
				i == len - 1, burst);
	endtask

	// Receiver: random stalls, quiet stretches, and one long hold-off that backs
	// the block up into its input.
	initial begin
		int stall_left;
		int cycle;
		bit hold_done;
		stall_left = 0;
		cycle = 0;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			cycle++;
			if (arst_n && out_valid && out_ready)
				board.check_item(char_out, last_out);
			if (!hold_done && board.results_checked >= 400) begin
				hold_done = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (cycle % 1024 < 200) begin
				out_ready <= 1'b1;
			end else begin
				stall_left = pick_gap();
				out_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	initial begin
		int waited;
		board = new();
		items_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_in = 8'h00;
		last_in = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero byte, pronoun before punctuation, before a letter and after a tab,
		// high bytes, two blanks before I, and a message whose last item is a candidate 'i' after a blank.
		send_item(8'h00, 1'b0, 1'b0);
		send_text("A I! AN IT\tI?", 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h80, 1'b0, 1'b0);
		send_text("X  I. z", 1'b0);
		send_item(8'h0D, 1'b0, 1'b0);
		send_item(utsc_pkg::CHAR_UPPER_I, 1'b1, 1'b0);

		while (items_sent < 1350)
			send_random_message();
		in_valid <= 1'b0;

		waited = 0;
		while (board.expected_bytes.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (16) @(posedge clk);
		board.flush_leftovers();
		if (board.errors == 0)
			$display("upper_text_to_sentence_case_top: match");
		else
			$display("upper_text_to_sentence_case_top: mismatch");
		$finish;
	end

	initial begin
		#8000000;
		$display("upper_text_to_sentence_case_top: mismatch");
		$finish;
	end
endmodule
